// ----- sv/rfa_pkg.sv -----
`timescale 1ns / 1ps
package rfa_pkg;

  localparam int OW = 16;
  localparam int MW = 2 * OW + 1;
  localparam int KW = $clog2(MW + 1);
  localparam int CW = $clog2(MW);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] SEL_P0 = 2'd0;
  localparam logic [1:0] SEL_P1 = 2'd1;
  localparam logic [1:0] SEL_DEN = 2'd2;

  localparam logic [MW-1:0] DEN_MAX = MW'(64'h3FFF_FFFF);
  localparam logic [MW-1:0] POS_MAX = MW'(64'h7FFF_FFFF);
  localparam logic [MW-1:0] NEG_MAX = MW'(64'h8000_0000);

  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       sum_en;
    logic       gcd_init;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic gcd_done;
  } sts_t;

endpackage

// ----- sv/rfa_in_if.sv -----
`timescale 1ns / 1ps
interface rfa_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic signed [rfa_pkg::OW-1:0] left_numerator;
  logic signed [rfa_pkg::OW-1:0] left_denominator;
  logic signed [rfa_pkg::OW-1:0] right_numerator;
  logic signed [rfa_pkg::OW-1:0] right_denominator;

  modport source (output valid, opcode, left_numerator, left_denominator,
                  right_numerator, right_denominator, input ready);
  modport sink (input valid, opcode, left_numerator, left_denominator,
                right_numerator, right_denominator, output ready);
endinterface

// ----- sv/rfa_out_if.sv -----
`timescale 1ns / 1ps
interface rfa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_numerator;
  logic [29:0]        result_denominator;
  logic               status;

  modport source (output valid, result_numerator, result_denominator, status,
                  input ready);
  modport sink (input valid, result_numerator, result_denominator, status,
                output ready);
endinterface

// ----- sv/rfa_datapath.sv -----
`timescale 1ns / 1ps
module rfa_datapath (
  input  logic                          clk,
  input  rfa_pkg::cmd_t                 cmd,
  output rfa_pkg::sts_t                 sts,
  input  logic [1:0]                    opcode,
  input  logic [rfa_pkg::OW-1:0]        left_numerator,
  input  logic [rfa_pkg::OW-1:0]        left_denominator,
  input  logic [rfa_pkg::OW-1:0]        right_numerator,
  input  logic [rfa_pkg::OW-1:0]        right_denominator,
  output logic signed [31:0]            result_numerator,
  output logic [29:0]                   result_denominator,
  output logic                          status
);
  localparam int OW = rfa_pkg::OW;
  localparam int MW = rfa_pkg::MW;

  logic [1:0]    op;
  logic [OW-1:0] ln_m, ld_m, rn_m, rd_m;
  logic          ln_s, ld_s, rn_s, rd_s;
  logic [MW-1:0] p0_m, p1_m, dp_m;
  logic          p0_s, p1_s, dp_s;
  logic [MW-1:0] n_m, d_m;
  logic          res_neg;
  logic [MW-1:0] ga, gb, gdiv;
  logic [rfa_pkg::KW-1:0] gk;
  logic [MW-1:0] qn, qd, rem_n, rem_d;

  logic [OW-1:0]   ma, mb;
  logic            sa, sb;
  logic [2*OW-1:0] prod;
  logic            prod_s;
  logic            s1_s;
  logic [MW-1:0]   sum_m;
  logic            sum_s;
  logic [MW-1:0]   tn, td;
  logic [MW-1:0]   nm_out;
  logic            range_err;

  // operand magnitude and sign
  function automatic logic [OW-1:0] mag_of(input logic [OW-1:0] v);
    return v[OW-1] ? (~v + OW'(1)) : v;
  endfunction

  always_comb begin
    ma = ln_m; sa = ln_s; mb = rd_m; sb = rd_s;
    case (cmd.mul_sel)
      rfa_pkg::SEL_P0: begin
        ma = ln_m; sa = ln_s;
        if (op == rfa_pkg::OP_MUL) begin
          mb = rn_m; sb = rn_s;
        end else begin
          mb = rd_m; sb = rd_s;
        end
      end
      rfa_pkg::SEL_P1: begin
        ma = rn_m; sa = rn_s; mb = ld_m; sb = ld_s;
      end
      rfa_pkg::SEL_DEN: begin
        if (op == rfa_pkg::OP_DIV) begin
          ma = rn_m; sa = rn_s;
        end else begin
          ma = rd_m; sa = rd_s;
        end
        mb = ld_m; sb = ld_s;
      end
      default: begin
        ma = ln_m; sa = ln_s; mb = rd_m; sb = rd_s;
      end
    endcase
  end

  assign prod   = ma * mb;
  assign prod_s = (prod != '0) && (sa != sb);

  // signed-magnitude add of the two cross products; multiply and divide pass p0 through
  always_comb begin
    s1_s = (op == rfa_pkg::OP_SUB && p1_m != '0) ? ~p1_s : p1_s;
    if (op == rfa_pkg::OP_MUL || op == rfa_pkg::OP_DIV) begin
      sum_m = p0_m; sum_s = p0_s;
    end else if (p0_s == s1_s) begin
      sum_m = p0_m + p1_m; sum_s = p0_s;
    end else if (p0_m >= p1_m) begin
      sum_m = p0_m - p1_m; sum_s = p0_s;
    end else begin
      sum_m = p1_m - p0_m; sum_s = s1_s;
    end
    if (sum_m == '0) sum_s = 1'b0;
  end

  // one restoring step for both quotients
  always_comb begin
    tn = {rem_n[MW-2:0], qn[MW-1]};
    td = {rem_d[MW-2:0], qd[MW-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op   <= opcode;
      ln_m <= mag_of(left_numerator);    ln_s <= left_numerator[OW-1];
      ld_m <= mag_of(left_denominator);  ld_s <= left_denominator[OW-1];
      rn_m <= mag_of(right_numerator);   rn_s <= right_numerator[OW-1];
      rd_m <= mag_of(right_denominator); rd_s <= right_denominator[OW-1];
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        rfa_pkg::SEL_P0: begin p0_m <= MW'(prod); p0_s <= prod_s; end
        rfa_pkg::SEL_P1: begin p1_m <= MW'(prod); p1_s <= prod_s; end
        default:         begin dp_m <= MW'(prod); dp_s <= prod_s; end
      endcase
    end
    if (cmd.sum_en) begin
      n_m     <= sum_m;
      d_m     <= dp_m;
      res_neg <= sum_s != dp_s;
    end
    if (cmd.gcd_init) begin
      ga <= n_m; gb <= d_m; gk <= '0;
    end else if (cmd.gcd_step) begin
      if (!ga[0] && !gb[0]) begin
        ga <= ga >> 1; gb <= gb >> 1; gk <= gk + 1'b1;
      end else if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else if (ga >= gb) begin
        ga <= (ga - gb) >> 1;
      end else begin
        gb <= (gb - ga) >> 1;
      end
    end
    if (cmd.div_init) begin
      gdiv  <= (ga | gb) << gk;
      qn    <= n_m;   qd <= d_m;
      rem_n <= '0;    rem_d <= '0;
    end else if (cmd.div_step) begin
      if (tn >= gdiv) begin
        rem_n <= tn - gdiv; qn <= {qn[MW-2:0], 1'b1};
      end else begin
        rem_n <= tn;        qn <= {qn[MW-2:0], 1'b0};
      end
      if (td >= gdiv) begin
        rem_d <= td - gdiv; qd <= {qd[MW-2:0], 1'b1};
      end else begin
        rem_d <= td;        qd <= {qd[MW-2:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      if (d_m == '0) begin
        result_numerator <= '0; result_denominator <= 30'd1; status <= 1'b1;
      end else if (n_m == '0) begin
        result_numerator <= '0; result_denominator <= 30'd1; status <= 1'b0;
      end else if (range_err) begin
        result_numerator <= '0; result_denominator <= 30'd1; status <= 1'b1;
      end else begin
        result_numerator <= nm_out[31:0]; result_denominator <= qd[29:0];
        status <= 1'b0;
      end
    end
  end

  assign range_err = (qd > rfa_pkg::DEN_MAX) ||
                     (qn > (res_neg ? rfa_pkg::NEG_MAX : rfa_pkg::POS_MAX));
  assign nm_out    = res_neg ? (~qn + MW'(1)) : qn;

  assign sts.zero     = (n_m == '0) || (d_m == '0);
  assign sts.gcd_done = (ga == '0) || (gb == '0);
endmodule

// ----- sv/rfa_control.sv -----
`timescale 1ns / 1ps
module rfa_control (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rfa_pkg::cmd_t cmd,
  input  rfa_pkg::sts_t sts
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL0 = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_GCD  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0]             state, state_next;
  logic [rfa_pkg::CW-1:0] cnt, cnt_next;
  logic                   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) state_next = ST_MUL0;
      end
      ST_MUL0: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = rfa_pkg::SEL_P0; state_next = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = rfa_pkg::SEL_P1; state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = rfa_pkg::SEL_DEN; state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1; state_next = ST_GCD;
      end
      ST_GCD: begin
        // first cycle here only loads the GCD pair unless a zero cuts it short
        if (sts.zero) begin
          state_next = ST_FIN;
        end else if (cnt == '0) begin
          cmd.gcd_init = 1'b1; cnt_next = rfa_pkg::CW'(1);
        end else if (sts.gcd_done) begin
          cmd.div_init = 1'b1; cnt_next = '0; state_next = ST_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == rfa_pkg::CW'(rfa_pkg::MW - 1)) begin
          cnt_next = '0; state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1; cnt_next = '0; state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.load_out)  out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

// ----- sv/rational_fraction_alu_core.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Word
// in_ch    in   opcode, left/right numerator and denominator (signed)
// out_ch   out  result_numerator, result_denominator, status
//
// One word at a time: the multiplies, a sum, the binary-GCD steps, then
// restoring division for both quotients together.
// A zero numerator or denominator skips the GCD and divider.
// rst is synchronous and clears the controller and the output valid flag.
// The result sits in an output register, so the next word is accepted while
// it waits; a finished word stalls only if that register is still full.
module rational_fraction_alu_core (
  input logic        clk,
  input logic        rst,
  rfa_in_if.sink     in_ch,
  rfa_out_if.source  out_ch
);
  rfa_pkg::cmd_t cmd;
  rfa_pkg::sts_t sts;

  // sequence the multiply, reduce and divide phases
  rfa_control u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // hold operands, products, GCD pair, quotients and the result word
  rfa_datapath u_dp (
    .clk                (clk),
    .cmd                (cmd),
    .sts                (sts),
    .opcode             (in_ch.opcode),
    .left_numerator     (in_ch.left_numerator),
    .left_denominator   (in_ch.left_denominator),
    .right_numerator    (in_ch.right_numerator),
    .right_denominator  (in_ch.right_denominator),
    .result_numerator   (out_ch.result_numerator),
    .result_denominator (out_ch.result_denominator),
    .status             (out_ch.status)
  );
endmodule

// ----- tb/rfa_fraction_scoreboard.sv -----
`timescale 1ns / 1ps
class rfa_fraction_scoreboard;
  typedef struct {
    logic signed [31:0] num;
    logic [29:0]        den;
    logic               status;
  } fraction_t;

  fraction_t pending_q[$];
  int        mismatch_count;

  function automatic void mag_of(input logic [15:0] raw, output bit neg,
                                 output longint unsigned mag);
    neg = raw[15];
    mag = neg ? (64'd65536 - raw) : raw;
  endfunction

  // Signed-magnitude add; zero is always positive.
  function automatic void sm_sum(input bit an, input longint unsigned am,
                                 input bit bn, input longint unsigned bm,
                                 output bit rn, output longint unsigned rm);
    if (an == bn) begin
      rn = an;
      rm = am + bm;
    end else if (am >= bm) begin
      rn = an;
      rm = am - bm;
    end else begin
      rn = bn;
      rm = bm - am;
    end
    if (rm == 0) rn = 0;
  endfunction

  function void note_operands(logic [1:0] op, logic [15:0] ln, logic [15:0] ld,
                              logic [15:0] rn, logic [15:0] rd);
    bit                lnn, ldn, rnn, rdn, nn, dn, pn, qn, neg;
    longint unsigned   lnm, ldm, rnm, rdm, nm, dm, pm, qm, a, b, t;
    fraction_t         f;
    mag_of(ln, lnn, lnm);
    mag_of(ld, ldn, ldm);
    mag_of(rn, rnn, rnm);
    mag_of(rd, rdn, rdm);
    pm = lnm * rdm; pn = (pm != 0) && (lnn != rdn);
    qm = rnm * ldm; qn = (qm != 0) && (rnn != ldn);
    dm = ldm * rdm; dn = (dm != 0) && (ldn != rdn);
    case (op)
      rfa_pkg::OP_ADD: sm_sum(pn, pm, qn, qm, nn, nm);
      rfa_pkg::OP_SUB: sm_sum(pn, pm, (qm != 0) && !qn, qm, nn, nm);
      rfa_pkg::OP_MUL: begin
        nm = lnm * rnm; nn = (nm != 0) && (lnn != rnn);
      end
      default: begin
        nm = pm; nn = pn; dm = qm; dn = qn;
      end
    endcase
    f.num = 0; f.den = 1; f.status = 0;
    if (dm == 0) f.status = 1;
    else if (nm != 0) begin
      neg = nn != dn;
      a = nm; b = dm;
      while (b != 0) begin
        t = a % b; a = b; b = t;
      end
      nm = nm / a; dm = dm / a;
      if (dm > 64'h3FFF_FFFF || nm > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF))
        f.status = 1;
      else begin
        f.num = neg ? -nm : nm;
        f.den = dm;
      end
    end
    pending_q.push_back(f);
  endfunction

  function bit check_result(logic signed [31:0] num, logic [29:0] den,
                            logic status, output string msg);
    fraction_t f;
    if (pending_q.size() == 0) begin
      msg = $sformatf("unexpected result %0d/%0d st %0d", num, den, status);
      return 0;
    end
    f = pending_q.pop_front();
    if (num !== f.num || den !== f.den || status !== f.status) begin
      msg = $sformatf("got %0d/%0d st %0d, want %0d/%0d st %0d",
                      num, den, status, f.num, f.den, f.status);
      return 0;
    end
    return 1;
  endfunction
endclass

// ----- tb/rational_fraction_alu_core_test.sv -----
`timescale 1ns / 1ps
module rational_fraction_alu_core_test;

  logic clk = 0;
  logic rst = 1;
  rfa_in_if  in_ch();
  rfa_out_if out_ch();

  rational_fraction_alu_core u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  rfa_fraction_scoreboard fraction_sb = new();
  int  error_count = 0;
  int  cycle_count = 0;
  bit  stim_done = 0;
  bit  calm = 0;       // no idling on either side
  bit  hold_off = 0;   // receiver holds off for a long stretch

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Offer one word; hold it until accepted, idling at random first.
  task automatic send_word(logic [1:0] op, logic [15:0] ln, logic [15:0] ld,
                           logic [15:0] rn, logic [15:0] rd);
    while (!calm && $urandom_range(99) < 31) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.left_numerator <= ln;
    in_ch.left_denominator <= ld;
    in_ch.right_numerator <= rn;
    in_ch.right_denominator <= rd;
    do @(posedge clk); while (!in_ch.ready);
    fraction_sb.note_operands(op, ln, ld, rn, rd);
  endtask

  // Half small magnitudes so the GCD does real work; some full range and edges.
  function automatic logic [15:0] pick_field();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return 16'($urandom());
      default: return 16'($signed($urandom_range(64)) - 32);
    endcase
  endfunction

  initial begin
    logic [15:0] edges[6] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
                              16'h8000, 16'h8001};
    in_ch.valid = 0;
    in_ch.opcode = rfa_pkg::OP_ADD;
    in_ch.left_numerator = 0;
    in_ch.left_denominator = 0;
    in_ch.right_numerator = 0;
    in_ch.right_denominator = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: each op on small values, extremes, zero numerator, zero denominator; then divide by zero.
    for (int op = 0; op < 4; op++) begin
      send_word(2'(op), 16'd3, 16'd4, 16'd5, 16'hFFFA);
      send_word(2'(op), 16'h7FFF, 16'h8000, 16'h8000, 16'h0001);
      send_word(2'(op), 16'h8000, 16'h0001, 16'h8000, 16'h0001);
      send_word(2'(op), 16'd0, 16'd7, 16'd2, 16'd3);
      send_word(2'(op), 16'd1, 16'd0, 16'd2, 16'd3);
    end
    send_word(rfa_pkg::OP_DIV, 16'd1, 16'd2, 16'd0, 16'd5);
    for (int i = 0; i < 4; i++)
      send_word(rfa_pkg::OP_MUL, edges[i+2], edges[i], edges[5-i], edges[i+1]);
    // Random; a calm stretch in the middle, a long hold-off near the start.
    for (int i = 0; i < 1550; i++) begin
      calm = (i >= 700 && i < 850);
      hold_off = (i >= 100 && i < 110);
      send_word(2'($urandom_range(3)), pick_field(), pick_field(), pick_field(),
                pick_field());
    end
    in_ch.valid <= 0;
    hold_off = 0;
    stim_done = 1;
  end

  // Receiver: random stalls; ready is dropped during hold-off.
  initial begin
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ch.ready <= 0;
        repeat (2000) @(posedge clk);
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 31);
    end
  end

  // Check every accepted result word against the oldest prediction.
  always @(posedge clk) begin
    string msg;
    if (!rst && out_ch.valid && out_ch.ready)
      if (!fraction_sb.check_result(out_ch.result_numerator,
                                    out_ch.result_denominator, out_ch.status, msg))
        report(msg);
  end

  // End: drain, let the latency pass, decide. Timeout is generous.
  initial begin
    while (!(stim_done && fraction_sb.pending_q.size() == 0)) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0 && fraction_sb.pending_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("Test completed with failures");
      $finish;
    end
  end
endmodule

// ----- filelist.f -----
sv/rfa_pkg.sv
sv/rfa_in_if.sv
sv/rfa_out_if.sv
sv/rfa_datapath.sv
sv/rfa_control.sv
sv/rational_fraction_alu_core.sv
tb/rfa_fraction_scoreboard.sv
tb/rational_fraction_alu_core_test.sv
